>>> hdl/assert_macros.svh
// Assertion helpers, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ANY(label, prop, msg)
`endif
`endif

>>> hdl/med3_pkg.sv
package med3_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CNT_W      = 24;
    localparam int FIFO_DEPTH = 4;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_frame;
    } t_out_item;

    // border flags of one output position
    typedef struct packed {
        logic top_out;
        logic mid_out;
        logic bot_out;
        logic left_out;
        logic right_out;
    } t_edge;

    typedef struct packed {
        logic             act;
        logic             emit;
        logic             last;
        logic             hit;
        t_edge            edges;
        logic [COL_W-1:0] col;
    } t_s1_ctl;

    function automatic logic [11:0] clamp_w(logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (v == 12'd0) r = 12'd1;
        else if (v > 12'(MAX_WIDTH)) r = 12'(MAX_WIDTH);
        return r;
    endfunction

    function automatic logic [12:0] clamp_h(logic [12:0] v);
        logic [12:0] r;
        r = v;
        if (v == 13'd0) r = 13'd1;
        else if (v > 13'(MAX_HEIGHT)) r = 13'(MAX_HEIGHT);
        return r;
    endfunction
endpackage

>>> hdl/median_3x3_rgb_border_adaptive.sv
// A pixel's median leaves after the transfer of the input item W+1 positions later,
// passing through line memory read, window update, rank select and output queue.
// Throughput: one item per cycle while o_stall is low; the line memory is read and
// written for each windowed item. A configuration write stalls the input while a
// bit-serial divider re-derives the output column and row. Reset is synchronous,
// active low; it clears counters, window and queue but not the line memory.
`include "assert_macros.svh"
module median_3x3_rgb_border_adaptive (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  med3_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output med3_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [0:0]          i_cfg_idx,
    input  logic [12:0]         i_cfg_wdata
);
    import med3_pkg::*;

    logic [11:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [11:0] w_cl;
    logic [12:0] h_cl;
    logic [11:0] r_wc;
    logic [12:0] r_hc;
    logic [CNT_W-1:0] r_total, r_total_w;
    logic [12:0] r_wp1;

    logic [CNT_W-1:0] r_seen;
    logic [COL_W-1:0] r_in_col;
    logic [COL_W-1:0] r_cc;
    logic [CNT_W-1:0] r_cr;

    logic             r_div_busy, r_div_load;
    logic [4:0]       r_div_cnt;
    logic [CNT_W-1:0] r_dq;
    logic [11:0]      r_rem;
    logic [12:0]      div_tr;
    logic             div_ge;
    logic [11:0]      div_rem;
    logic [CNT_W-1:0] div_num;

    logic [47:0] r_line_mem [MAX_WIDTH];
    logic [47:0] r_rd;
    t_s1_ctl     r_s1;
    logic [23:0] r_s1_px;
    logic [47:0] r_s1_fwd;
    logic [23:0] top_eff, mid_eff;

    logic [23:0] r_win [3][3];
    logic [23:0] n_win [3][3];
    logic [23:0] r_s2_win [9];
    t_edge       r_s2_edges;
    logic        r_s2_emit, r_s2_last;

    t_out_item   r_fifo [FIFO_DEPTH];
    logic [$clog2(FIFO_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(FIFO_DEPTH):0]   r_cnt;
    logic [$clog2(FIFO_DEPTH):0]   reserved;
    logic push, pop;
    logic q_full;

    logic take, early, flush, emit, last, act;
    logic [23:0] px;
    t_edge edges;
    logic [COL_W-1:0] col_next;
    t_out_item med;

    assign w_cl = clamp_w(r_cfg_w);
    assign h_cl = clamp_h(r_cfg_h);

    // ---------------- configuration and derived sizes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_FRAME_WIDTH;
            r_cfg_h <= RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_cfg_w <= i_cfg_wdata[11:0];
                REG_FRAME_HEIGHT: r_cfg_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wc      <= w_cl;
        r_hc      <= h_cl;
        r_total   <= CNT_W'({13'd0, w_cl} * {12'd0, h_cl});
        r_total_w <= r_total + CNT_W'(r_wc);
        r_wp1     <= {1'b0, w_cl} + 13'd1;
    end

    // ---------------- output position re-derivation after a size change ----------------
    assign div_num = (r_seen > CNT_W'(w_cl)) ? r_seen - CNT_W'(w_cl) - CNT_W'(1) : '0;
    assign div_tr  = {r_rem, r_dq[CNT_W-1]};
    assign div_ge  = div_tr >= {1'b0, w_cl};
    assign div_rem = div_ge ? 12'(div_tr - {1'b0, w_cl}) : div_tr[11:0];

    // ---------------- input stage ----------------
    assign reserved = r_cnt + ($clog2(FIFO_DEPTH)+1)'(r_s1.act & r_s1.emit)
                    + ($clog2(FIFO_DEPTH)+1)'(r_s2_emit);
    assign o_stall  = i_cfg_we || r_div_busy
                    || (reserved >= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH));
    assign take     = i_valid && !o_stall;
    assign early    = i_in.req_type && (r_seen < r_total);
    assign flush    = i_in.req_type || (r_seen >= r_total);
    assign act      = take && !early;
    assign emit     = r_seen >= CNT_W'(r_wp1);
    assign last     = emit && (r_seen >= r_total_w);
    assign px       = flush ? 24'd0 : {i_in.red_in, i_in.green_in, i_in.blue_in};
    assign col_next = ({1'b0, r_in_col} + 12'd1 >= r_wc) ? '0 : r_in_col + COL_W'(1);

    always_comb begin
        edges.top_out   = r_cr == '0;
        edges.mid_out   = r_cr >= CNT_W'(r_hc);
        edges.bot_out   = r_cr + CNT_W'(1) >= CNT_W'(r_hc);
        edges.left_out  = r_cc == '0;
        edges.right_out = {1'b0, r_cc} + 12'd1 >= r_wc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_in_col   <= '0;
            r_cc       <= '0;
            r_cr       <= '0;
            r_div_busy <= 1'b0;
            r_div_load <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cfg_we) begin
            r_div_busy <= 1'b1;
            r_div_load <= 1'b1;
        end else if (r_div_busy) begin
            if (r_div_load) begin
                r_dq       <= div_num;
                r_rem      <= '0;
                r_div_cnt  <= '0;
                r_div_load <= 1'b0;
            end else begin
                r_dq      <= {r_dq[CNT_W-2:0], div_ge};
                r_rem     <= div_rem;
                r_div_cnt <= r_div_cnt + 5'd1;
                if (r_div_cnt == 5'(CNT_W-1)) begin
                    r_div_busy <= 1'b0;
                    r_cc       <= div_rem[COL_W-1:0];
                    r_cr       <= {r_dq[CNT_W-2:0], div_ge};
                end
            end
        end else if (act) begin
            if (last) begin
                r_seen   <= '0;
                r_in_col <= '0;
                r_cc     <= '0;
                r_cr     <= '0;
            end else begin
                r_seen   <= r_seen + CNT_W'(1);
                r_in_col <= col_next;
                if (emit) begin
                    if ({1'b0, r_cc} + 12'd1 >= r_wc) begin
                        r_cc <= '0;
                        r_cr <= r_cr + CNT_W'(1);
                    end else begin
                        r_cc <= r_cc + COL_W'(1);
                    end
                end
            end
        end
    end

    // ---------------- line memory: read at transfer, write back in the next cycle ----------------
    assign top_eff = r_s1.hit ? r_s1_fwd[47:24] : r_rd[47:24];
    assign mid_eff = r_s1.hit ? r_s1_fwd[23:0]  : r_rd[23:0];

    always_ff @(posedge i_clk) begin
        if (act) r_rd <= r_line_mem[r_in_col];
        if (r_s1.act) r_line_mem[r_s1.col] <= {mid_eff, r_s1_px};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.act <= 1'b0;
        end else begin
            r_s1.act <= act;
        end
        r_s1.emit  <= emit;
        r_s1.last  <= last;
        r_s1.hit   <= r_s1.act && (r_s1.col == r_in_col);
        r_s1.edges <= edges;
        r_s1.col   <= r_in_col;
        r_s1_px    <= px;
        r_s1_fwd   <= {mid_eff, r_s1_px};
    end

    // ---------------- window ----------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = top_eff;
        n_win[1][2] = mid_eff;
        n_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    r_win[r][c] <= '0;
            r_s2_emit <= 1'b0;
        end else begin
            r_s2_emit <= r_s1.act && r_s1.emit;
            if (r_s1.act) begin
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        r_win[r][c] <= r_s1.last ? 24'd0 : n_win[r][c];
            end
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                r_s2_win[r*3+c] <= n_win[r][c];
        r_s2_edges <= r_s1.edges;
        r_s2_last  <= r_s1.last;
    end

    // ---------------- rank select median ----------------
    always_comb begin
        logic [8:0] vld;
        logic [3:0] n, half, rank;
        logic [7:0] vi, vj;
        logic [7:0] res [3];
        for (int e = 0; e < 9; e++) begin
            vld[e] = 1'b1;
            if (e / 3 == 0 && r_s2_edges.top_out)   vld[e] = 1'b0;
            if (e / 3 == 1 && r_s2_edges.mid_out)   vld[e] = 1'b0;
            if (e / 3 == 2 && r_s2_edges.bot_out)   vld[e] = 1'b0;
            if (e % 3 == 0 && r_s2_edges.left_out)  vld[e] = 1'b0;
            if (e % 3 == 2 && r_s2_edges.right_out) vld[e] = 1'b0;
        end
        n    = 4'($countones(vld));
        half = n >> 1;
        for (int k = 0; k < 3; k++) begin
            res[k] = 8'd0;
            for (int i = 0; i < 9; i++) begin
                vi   = r_s2_win[i][23-8*k -: 8];
                rank = 4'd0;
                for (int j = 0; j < 9; j++) begin
                    vj = r_s2_win[j][23-8*k -: 8];
                    if (j != i && vld[j] && ((vj < vi) || (vj == vi && j < i)))
                        rank = rank + 4'd1;
                end
                if (vld[i] && rank == half) res[k] = res[k] | vi;
            end
        end
        med.red_out       = res[0];
        med.green_out     = res[1];
        med.blue_out      = res[2];
        med.last_of_frame = r_s2_last;
    end

    // ---------------- output queue ----------------
    assign push    = r_s2_emit;
    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && !i_stall;
    assign o_out   = r_fifo[r_rp];
    assign q_full  = r_cnt == ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (push) r_fifo[r_wp] <= med;
    end

    `ASSERT_RST(a_fifo_bound, r_cnt <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH), "queue overflow")
    `ASSERT_RST(a_no_push_full, push |-> !q_full || pop, "push into full queue")
    `ASSERT_RST(a_busy_stalls, r_div_busy |-> o_stall, "transfer during recompute")
    `ASSERT_RST(a_fwd_source, r_s1.act && r_s1.hit |-> $past(r_s1.act), "forward without writer")
endmodule
